FILE: rtl/mm3_pkg.sv
package mm3_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 3;

    localparam logic [WORD_W-1:0] MIX_C1  = 32'hcc9e_2d51;
    localparam logic [WORD_W-1:0] MIX_C2  = 32'h1b87_3593;
    localparam logic [WORD_W-1:0] MIX_ADD = 32'he654_6b64;
    localparam logic [WORD_W-1:0] FIN_M1  = 32'h85eb_ca6b;
    localparam logic [WORD_W-1:0] FIN_M2  = 32'hc2b2_ae35;

    localparam logic [COUNT_W-1:0] FULL_BYTES = 3'd4;

    localparam int QUEUE_DEPTH_DEF = 4;

    // how the back end folds a word into the running hash
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_TAIL,
        KIND_FULL
    } t_kind;

    typedef struct packed {
        logic [WORD_W-1:0]  key;
        t_kind              kind;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/mm3_if.sv
interface mm3_in_if
    import mm3_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  data_word;
    logic [COUNT_W-1:0] valid_bytes;
    logic               last;

    modport source (output valid, output data_word, output valid_bytes, output last,
                    input ready);
    modport sink   (input valid, input data_word, input valid_bytes, input last,
                    output ready);
endinterface

interface mm3_out_if
    import mm3_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

FILE: rtl/mm3_front.sv
module mm3_front
    import mm3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    mm3_in_if.sink    i_in,
    input  t_q_status i_q_stat,
    output logic      o_push,
    output t_entry    o_entry
);

    logic   r_s1_valid;
    logic   r_s2_valid;
    t_entry r_s1;
    t_entry r_s2;
    t_entry n_s1;
    t_entry n_s2;

    logic               s2_move;
    logic               s2_free;
    logic               s1_free;
    logic               accept;
    logic               keep;
    logic [COUNT_W-1:0] cnt;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  k_rot;

    assign s2_move    = r_s2_valid && !i_q_stat.full;
    assign s2_free    = !r_s2_valid || s2_move;
    assign s1_free    = !r_s1_valid || s2_free;
    assign i_in.ready = s1_free;
    assign accept     = i_in.valid && s1_free;

    // counts above four mean a full word
    assign cnt = (i_in.valid_bytes > FULL_BYTES) ? FULL_BYTES : i_in.valid_bytes;

    always_comb begin
        unique case (cnt)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            3'd4:    mask = 32'hffff_ffff;
            default: mask = '0;
        endcase
    end

    always_comb begin
        n_s1.key   = (i_in.data_word & mask) * MIX_C1;
        n_s1.count = cnt;
        n_s1.last  = i_in.last;
        if (cnt == FULL_BYTES) begin
            n_s1.kind = KIND_FULL;
        end else if (cnt == '0) begin
            n_s1.kind = KIND_NONE;
        end else begin
            n_s1.kind = KIND_TAIL;
        end
    end

    // empty word that does not close the message is dropped here
    assign keep = (n_s1.kind != KIND_NONE) || i_in.last;

    assign k_rot = {r_s1.key[16:0], r_s1.key[31:17]};

    always_comb begin
        n_s2     = r_s1;
        n_s2.key = k_rot * MIX_C2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= accept && keep;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s2_free && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_push  = s2_move;
    assign o_entry = r_s2;

endmodule

FILE: rtl/mm3_queue.sv
module mm3_queue
    import mm3_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_wr_entry,
    input  logic      i_pop,
    output t_entry    o_rd_entry,
    output t_q_status o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rd_entry   = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

FILE: rtl/mm3_back.sv
module mm3_back
    import mm3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_entry,
    input  t_q_status i_q_stat,
    output logic      o_pop,
    mm3_out_if.source o_out
);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_FIN0,
        ST_FIN1,
        ST_FIN2
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [WORD_W-1:0] r_hash;
    logic [WORD_W-1:0] n_hash;
    logic [WORD_W-1:0] r_total;
    logic [WORD_W-1:0] n_total;
    logic [WORD_W-1:0] r_fin;
    logic [WORD_W-1:0] n_fin;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [WORD_W-1:0] r_out_hash;
    logic [WORD_W-1:0] n_out_hash;

    logic [WORD_W-1:0] mixed;
    logic [WORD_W-1:0] h_rot;
    logic [WORD_W-1:0] fin_in;

    assign mixed  = r_hash ^ i_entry.key;
    assign h_rot  = {mixed[18:0], mixed[31:19]};
    assign fin_in = r_hash ^ r_total;

    always_comb begin
        n_state     = r_state;
        n_hash      = r_hash;
        n_total     = r_total;
        n_fin       = r_fin;
        n_out_hash  = r_out_hash;
        n_out_valid = r_out_valid;
        o_pop       = 1'b0;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_ACCUM: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    case (i_entry.kind)
                        // times five as shift plus add
                        KIND_FULL: n_hash = h_rot + {h_rot[29:0], 2'b00} + MIX_ADD;
                        KIND_TAIL: n_hash = mixed;
                        default:   n_hash = r_hash;
                    endcase
                    n_total = r_total + {{(WORD_W - COUNT_W){1'b0}}, i_entry.count};
                    if (i_entry.last) begin
                        n_state = ST_FIN0;
                    end
                end
            end
            ST_FIN0: begin
                n_fin   = (fin_in ^ (fin_in >> 16)) * FIN_M1;
                n_hash  = '0;
                n_total = '0;
                n_state = ST_FIN1;
            end
            ST_FIN1: begin
                n_fin   = (r_fin ^ (r_fin >> 13)) * FIN_M2;
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                // wait here while the previous hash is still unclaimed
                if (!r_out_valid || o_out.ready) begin
                    n_out_hash  = r_fin ^ (r_fin >> 16);
                    n_out_valid = 1'b1;
                    n_state     = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_hash      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash      <= n_hash;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
            r_fin       <= n_fin;
            r_out_hash  <= n_out_hash;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;

endmodule

FILE: rtl/murmur3_32_stream_hash.sv
// murmurhash3 x86_32, seed 0, over a stream of little-endian 32-bit words
// throughput: one word per cycle while the queue has room; after a last word the back end
// runs its 3 finalizer steps before it pops the next word
// path to the hash: both key-scramble stages, queue write, accumulate, 3 finalizer steps
// synchronous active-low reset clears hash, byte count, queue and output valid
module murmur3_32_stream_hash
    import mm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mm3_in_if.sink    i_in,
    mm3_out_if.source o_out
);

    logic      q_push;
    logic      q_pop;
    t_entry    q_wr;
    t_entry    q_rd;
    t_q_status q_stat;

    mm3_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (q_push),
        .o_entry  (q_wr)
    );

    mm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_wr_entry (q_wr),
        .i_pop      (q_pop),
        .o_rd_entry (q_rd),
        .o_stat     (q_stat)
    );

    mm3_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (q_rd),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue read while empty");

    a_no_empty_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_wr.kind != KIND_NONE || q_wr.last))
        else $error("empty non-last item reached the queue");

    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

endmodule
